/* sv/swr_pkg.sv */
// Shared types, register indexes and constants for the sampling control word randomizer.
// Used by every module of the block; depends on nothing else.

package swr_pkg;

   // Default width of the random field that is ORed in at bit 32.
   localparam int unsigned RANDOM_BITS_DEF = 12;

   // Widths of the fixed fields.
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned PERIOD_W = 20;
   localparam int unsigned LFSR_W   = 16;
   localparam int unsigned OPW_W    = 20;
   localparam int unsigned CSR_IDX_W = 3;

   // LFSR seed after reset.
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hF00D;

   // Op count clamp limits and saturation limit.
   localparam logic [15:0] OP_CLAMP_LO = 16'h0081;
   localparam logic [15:0] OP_CLAMP_HI = 16'hFF80;
   localparam logic [15:0] OP_MAXCNT   = 16'hFFFF;

   // Bit positions in the control word.
   localparam int unsigned FETCH_RAND_EN_BIT = 57;
   localparam int unsigned FETCH_VAL_BIT     = 49;
   localparam int unsigned FETCH_ENABLE_BIT  = 48;
   localparam int unsigned OP_CNT_CTL_BIT    = 19;
   localparam int unsigned OP_VAL_BIT        = 18;
   localparam int unsigned OP_ENABLE_BIT     = 17;
   localparam int unsigned RAND_FIELD_LSB    = 32;

   // Commands carried by a request.
   typedef enum logic [1:0] {
      CMD_OP_START    = 2'd0,
      CMD_OP_REARM    = 2'd1,
      CMD_FETCH_START = 2'd2,
      CMD_FETCH_REARM = 2'd3
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OP_PERIOD        = 3'd0,
      CSR_FETCH_PERIOD     = 3'd1,
      CSR_FETCH_RANDOM_EN  = 3'd2,
      CSR_CUR_CNT_WRITABLE = 3'd3,
      CSR_DISPATCH_CAPABLE = 3'd4,
      CSR_COUNT_DISPATCHED = 3'd5,
      CSR_OP_SAMPLING_ON   = 3'd6,
      CSR_FETCH_SAMPLING_ON = 3'd7
   } csr_idx_type;

   // Request payload.
   typedef struct packed {
      cmd_type            cmd;
      logic [WORD_W-1:0]  status_word;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [WORD_W-1:0]  control_word;
      logic               write_word;
   } rsp_type;

   // Configuration register contents.
   typedef struct packed {
      logic [PERIOD_W-1:0] op_period;
      logic [PERIOD_W-1:0] fetch_period;
      logic                fetch_random_enable;
      logic                current_count_writable;
      logic                dispatch_count_capable;
      logic                count_dispatched;
      logic                op_sampling_on;
      logic                fetch_sampling_on;
   } cfg_type;

   // State update produced by the word builder for one transaction.
   typedef struct packed {
      logic               lfsr_step;
      logic [LFSR_W-1:0]  lfsr_next;
      logic               op_load;
      logic [OPW_W-1:0]   op_word_next;
   } state_upd_type;

endpackage

/* sv/swr_csr.sv */
// Configuration register file of the sampling control word randomizer.
// Depends on swr_pkg for the register indexes and the cfg_type struct.

module swr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  swr_pkg::csr_idx_type          csr_index,
   input  logic [swr_pkg::PERIOD_W-1:0]  csr_wdata,
   output swr_pkg::cfg_type              cfg
);
   import swr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register; the port is always ready.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OP_PERIOD:         cfg_in.op_period              = csr_wdata;
            CSR_FETCH_PERIOD:      cfg_in.fetch_period           = csr_wdata;
            CSR_FETCH_RANDOM_EN:   cfg_in.fetch_random_enable    = csr_wdata[0];
            CSR_CUR_CNT_WRITABLE:  cfg_in.current_count_writable = csr_wdata[0];
            CSR_DISPATCH_CAPABLE:  cfg_in.dispatch_count_capable = csr_wdata[0];
            CSR_COUNT_DISPATCHED:  cfg_in.count_dispatched       = csr_wdata[0];
            CSR_OP_SAMPLING_ON:    cfg_in.op_sampling_on         = csr_wdata[0];
            CSR_FETCH_SAMPLING_ON: cfg_in.fetch_sampling_on      = csr_wdata[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // All registers clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/swr_build.sv */
// Combinational control word builder: one transaction in, one response and a state update out.
// Depends on swr_pkg for the payload types, the command codes and the bit positions.

module swr_build #(
   parameter int unsigned RANDOM_BITS = swr_pkg::RANDOM_BITS_DEF
) (
   input  swr_pkg::cfg_type               cfg,
   input  swr_pkg::req_type               item,
   input  logic [swr_pkg::LFSR_W-1:0]     lfsr,
   input  logic [swr_pkg::OPW_W-1:0]      op_word,
   output swr_pkg::rsp_type               rsp,
   output swr_pkg::state_upd_type         upd
);
   import swr_pkg::*;

   localparam logic [16:0] OP_OFFSET = 17'(1) << (RANDOM_BITS - 5);

   logic [LFSR_W-1:0] lfsr_next;
   logic              fb;
   logic [15:0]       base;
   logic [15:0]       base_clamped;
   logic [16:0]       base_sum;
   logic [15:0]       base_sat;
   logic [15:0]       base_sel;
   logic [OPW_W-1:0]  op_new;
   logic [OPW_W-1:0]  op_src;
   logic [WORD_W-1:0] op_ext;
   logic [WORD_W-1:0] rand_add;
   logic [WORD_W-1:0] rand_or;
   logic [WORD_W-1:0] op_rand;
   logic [WORD_W-1:0] fetch_new;
   logic [WORD_W-1:0] fetch_rearm;

   // One Fibonacci step: taps at bits 0, 2, 3 and 5, new bit enters at the top.
   assign fb        = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
   assign lfsr_next = {fb, lfsr[LFSR_W-1:1]};

   // Op base period: clamp it, or add the offset and saturate.
   assign base         = cfg.op_period[PERIOD_W-1:4];
   assign base_clamped = (base < OP_CLAMP_LO) ? OP_CLAMP_LO :
                         (base > OP_CLAMP_HI) ? OP_CLAMP_HI : base;
   assign base_sum     = {1'b0, base} + OP_OFFSET;
   assign base_sat     = base_sum[16] ? OP_MAXCNT : base_sum[15:0];
   assign base_sel     = cfg.current_count_writable ? base_sat : base_clamped;

   // Op word before randomization: count control, enable and the base count.
   always_comb begin
      op_new = {{(OPW_W-16){1'b0}}, base_sel};
      op_new[OP_CNT_CTL_BIT] = cfg.dispatch_count_capable & cfg.count_dispatched;
      op_new[OP_ENABLE_BIT]  = 1'b1;
   end

   // Randomize with the stepped LFSR value: signed byte add, or random field at bit 32.
   assign op_src   = (item.cmd == CMD_OP_START) ? op_new : op_word;
   assign op_ext   = {{(WORD_W-OPW_W){1'b0}}, op_src};
   assign rand_add = op_ext + {{(WORD_W-8){lfsr_next[11]}}, lfsr_next[11:4]};
   assign rand_or  = op_ext | (WORD_W'(lfsr_next[RANDOM_BITS-1:0]) << RAND_FIELD_LSB);
   assign op_rand  = cfg.current_count_writable ? rand_or : rand_add;

   // Fetch words: fresh from the configuration, or rearmed from the status word.
   always_comb begin
      fetch_new = {{(WORD_W-16){1'b0}}, cfg.fetch_period[PERIOD_W-1:4]};
      fetch_new[FETCH_RAND_EN_BIT] = cfg.fetch_random_enable;
      fetch_new[FETCH_ENABLE_BIT]  = 1'b1;
   end

   always_comb begin
      fetch_rearm = item.status_word;
      fetch_rearm[FETCH_VAL_BIT]    = 1'b0;
      fetch_rearm[31:16]            = '0;
      fetch_rearm[FETCH_ENABLE_BIT] = 1'b1;
   end

   // Select the response and the state update by command.
   always_comb begin
      rsp              = '0;
      upd              = '0;
      upd.lfsr_next    = lfsr_next;
      upd.op_word_next = op_new;
      unique case (item.cmd)
         CMD_OP_START: begin
            if (cfg.op_sampling_on) begin
               rsp.control_word = op_rand;
               rsp.write_word   = 1'b1;
               upd.lfsr_step    = 1'b1;
               upd.op_load      = 1'b1;
            end
         end
         CMD_OP_REARM: begin
            if (cfg.op_sampling_on && item.status_word[OP_VAL_BIT]) begin
               rsp.control_word = op_rand;
               rsp.write_word   = 1'b1;
               upd.lfsr_step    = 1'b1;
            end
         end
         CMD_FETCH_START: begin
            if (cfg.fetch_sampling_on) begin
               rsp.control_word = fetch_new;
               rsp.write_word   = 1'b1;
            end
         end
         CMD_FETCH_REARM: begin
            if (cfg.fetch_sampling_on && item.status_word[FETCH_VAL_BIT]) begin
               rsp.control_word = fetch_rearm;
               rsp.write_word   = 1'b1;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

/* sv/sampling_ctl_word_randomizer.sv */
// Top level of the sampling control word randomizer: input register, builder, result register.
// Depends on swr_pkg, swr_csr and swr_build.
//
//   Channel  Direction  Handshake                 Payload
//   req      in         req_valid / req_stall     swr_pkg::req_type (cmd, status_word)
//   rsp      out        rsp_valid / rsp_stall     swr_pkg::rsp_type (control_word, write_word)
//   csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One transaction per cycle while rsp_stall is low; each passes the input and result registers.
// The LFSR and the stored op word update in the cycle a transaction leaves the input register.
// Synchronous active-high reset clears the configuration, the valid flags, the LFSR (to its
// seed) and the stored op word. A stalled response holds; the input register keeps
// accepting until it is full, and req_stall rises only when both registers are occupied.

module sampling_ctl_word_randomizer #(
   parameter int unsigned RANDOM_BITS = swr_pkg::RANDOM_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  swr_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output swr_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  swr_pkg::csr_idx_type          csr_index,
   input  logic [swr_pkg::PERIOD_W-1:0]  csr_wdata
);
   import swr_pkg::*;

   cfg_type           cfg;
   logic              s1_valid_ff;
   req_type           s1_item_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [LFSR_W-1:0] lfsr_ff;
   logic [LFSR_W-1:0] lfsr_in;
   logic [OPW_W-1:0]  op_word_ff;
   logic [OPW_W-1:0]  op_word_in;
   rsp_type           rsp_next;
   state_upd_type     upd;
   logic              out_free;
   logic              s1_move;
   logic              req_take;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   swr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Builder works on the registered transaction with the current state.
   swr_build #(
      .RANDOM_BITS (RANDOM_BITS)
   ) u_build (
      .cfg     (cfg),
      .item    (s1_item_ff),
      .lfsr    (lfsr_ff),
      .op_word (op_word_ff),
      .rsp     (rsp_next),
      .upd     (upd)
   );

   // Flow control between the two register stages.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // State advances only when its transaction moves into the result register.
   assign lfsr_in    = (s1_move && upd.lfsr_step) ? upd.lfsr_next : lfsr_ff;
   assign op_word_in = (s1_move && upd.op_load) ? upd.op_word_next : op_word_ff;

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lfsr_ff      <= LFSR_SEED;
         op_word_ff   <= '0;
      end else begin
         if (req_take || s1_move) begin
            s1_valid_ff <= req_take;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         lfsr_ff    <= lfsr_in;
         op_word_ff <= op_word_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_payload;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   // A response that asks for no write carries a zero word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.write_word) |-> (rsp_payload.control_word == '0))
      else $error("response without write carries a nonzero word");

   // The LFSR never falls into the all-zero lock-up state.
   assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("LFSR reached zero");

   // The LFSR holds unless an op word leaves the input register.
   assert property (@(posedge clock) disable iff (reset)
      !(s1_move && upd.lfsr_step) |=> $stable(lfsr_ff))
      else $error("LFSR stepped without an op word");

   // A full input register with a blocked result register stalls the request side.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request accepted with both stages full");
`endif

endmodule

/* verif/tb_sampling_ctl_word_randomizer.sv */
// Self-checking testbench for the sampling control word randomizer. It runs a directed
// table and then random traffic under several register settings, and checks every
// response against the table or a built-in predictor. Depends on swr_pkg and the RTL.

module tb_sampling_ctl_word_randomizer;
   timeunit 1ns;
   timeprecision 1ps;

   import swr_pkg::*;

   localparam int unsigned RAND_BITS     = RANDOM_BITS_DEF;
   localparam int unsigned RANDOM_PHASES = 9;
   localparam int unsigned PHASE_ITEMS   = 100;

   // One row of the directed table: a register write or a request.
   typedef struct {
      bit                  is_cfg;
      csr_idx_type         idx;
      logic [PERIOD_W-1:0] wdata;
      cmd_type             cmd;
      logic [WORD_W-1:0]   status;
      bit                  has_exp;
      logic [WORD_W-1:0]   exp_word;
      logic                exp_wr;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   csr_idx_type         csr_index = CSR_OP_PERIOD;
   logic [PERIOD_W-1:0] csr_wdata = '0;

   // Predictor state and shadow copy of the registers.
   cfg_type             cfg_shadow = '0;
   logic [LFSR_W-1:0]   lfsr_state = LFSR_SEED;
   logic [WORD_W-1:0]   op_word_state = '0;

   rsp_type             expected_words[$];
   stim_row_type        directed_rows[$];
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         mismatches = 0;
   int unsigned         words_checked = 0;
   int unsigned         words_written = 0;
   int unsigned         reg_writes = 0;

   sampling_ctl_word_randomizer #(.RANDOM_BITS(RAND_BITS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Free-running clock, 12 ns period.
   initial begin
      forever #6 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #5ms;
      $display("sampling_ctl_word_randomizer regression: fail");
      $finish;
   end

   // Steps the LFSR and applies the randomization chosen by the current method.
   function automatic logic [WORD_W-1:0] randomize_op_word(logic [WORD_W-1:0] w);
      logic [LFSR_W-1:0] r;
      r = {lfsr_state[0] ^ lfsr_state[2] ^ lfsr_state[3] ^ lfsr_state[5], lfsr_state[15:1]};
      lfsr_state = r;
      if (!cfg_shadow.current_count_writable)
         return w + {{56{r[11]}}, r[11:4]};
      return w | (64'(r[RAND_BITS-1:0]) << RAND_FIELD_LSB);
   endfunction

   // Computes the control word that one request produces, updating the predictor state.
   function automatic rsp_type build_control_word(req_type t);
      rsp_type     res;
      logic [16:0] base;
      res = '0;
      case (t.cmd)
         CMD_OP_START: if (cfg_shadow.op_sampling_on) begin
            base = {1'b0, cfg_shadow.op_period[19:4]};
            if (!cfg_shadow.current_count_writable) begin
               if (base < {1'b0, OP_CLAMP_LO}) base = {1'b0, OP_CLAMP_LO};
               if (base > {1'b0, OP_CLAMP_HI}) base = {1'b0, OP_CLAMP_HI};
            end else begin
               base = base + 17'(1 << (RAND_BITS - 5));
               if (base > {1'b0, OP_MAXCNT}) base = {1'b0, OP_MAXCNT};
            end
            op_word_state = 64'(base[15:0]);
            if (cfg_shadow.dispatch_count_capable && cfg_shadow.count_dispatched)
               op_word_state[OP_CNT_CTL_BIT] = 1'b1;
            op_word_state[OP_ENABLE_BIT] = 1'b1;
            res.control_word = randomize_op_word(op_word_state);
            res.write_word = 1'b1;
         end
         CMD_OP_REARM: if (cfg_shadow.op_sampling_on && t.status_word[OP_VAL_BIT]) begin
            res.control_word = randomize_op_word(op_word_state);
            res.write_word = 1'b1;
         end
         CMD_FETCH_START: if (cfg_shadow.fetch_sampling_on) begin
            res.control_word = 64'(cfg_shadow.fetch_period[19:4]);
            res.control_word[FETCH_RAND_EN_BIT] = cfg_shadow.fetch_random_enable;
            res.control_word[FETCH_ENABLE_BIT] = 1'b1;
            res.write_word = 1'b1;
         end
         CMD_FETCH_REARM: if (cfg_shadow.fetch_sampling_on && t.status_word[FETCH_VAL_BIT]) begin
            res.control_word = t.status_word;
            res.control_word[FETCH_VAL_BIT] = 1'b0;
            res.control_word[31:16] = '0;
            res.control_word[FETCH_ENABLE_BIT] = 1'b1;
            res.write_word = 1'b1;
         end
      endcase
      return res;
   endfunction

   // Directed table builders.
   function automatic void add_cfg_row(csr_idx_type idx, logic [PERIOD_W-1:0] value);
      stim_row_type row;
      row.is_cfg = 1'b1;
      row.idx = idx;
      row.wdata = value;
      row.cmd = CMD_OP_START;
      row.status = '0;
      row.has_exp = 1'b0;
      row.exp_word = '0;
      row.exp_wr = 1'b0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_req_row(cmd_type cmd, logic [WORD_W-1:0] status, bit has_exp,
                                       logic [WORD_W-1:0] exp_word, logic exp_wr);
      stim_row_type row;
      row.is_cfg = 1'b0;
      row.idx = CSR_OP_PERIOD;
      row.wdata = '0;
      row.cmd = cmd;
      row.status = status;
      row.has_exp = has_exp;
      row.exp_word = exp_word;
      row.exp_wr = exp_wr;
      directed_rows.push_back(row);
   endfunction

   // Response monitor and receiver stall generator.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual word %h write %b",
                     $time, rsp_payload.control_word, rsp_payload.write_word);
            mismatches++;
         end else begin
            exp_rsp = expected_words.pop_front();
            words_checked++;
            if (rsp_payload.write_word) words_written++;
            if (rsp_payload.control_word !== exp_rsp.control_word) begin
               $display("%0t: control_word mismatch: expected %h, actual %h",
                        $time, exp_rsp.control_word, rsp_payload.control_word);
               mismatches++;
            end
            if (rsp_payload.write_word !== exp_rsp.write_word) begin
               $display("%0t: write_word mismatch: expected %b, actual %b",
                        $time, exp_rsp.write_word, rsp_payload.write_word);
               mismatches++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Sends one request transaction and records its expected response on acceptance.
   task automatic send_request(req_type item, bit use_typed, rsp_type typed);
      rsp_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = build_control_word(item);
      expected_words.push_back(use_typed ? typed : predicted);
   endtask

   // Lowers the request and lets every outstanding response arrive.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes one register; csr_valid stays high for the caller to lower or reuse.
   task automatic write_reg(csr_idx_type idx, logic [PERIOD_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         CSR_OP_PERIOD:         cfg_shadow.op_period = value;
         CSR_FETCH_PERIOD:      cfg_shadow.fetch_period = value;
         CSR_FETCH_RANDOM_EN:   cfg_shadow.fetch_random_enable = value[0];
         CSR_CUR_CNT_WRITABLE:  cfg_shadow.current_count_writable = value[0];
         CSR_DISPATCH_CAPABLE:  cfg_shadow.dispatch_count_capable = value[0];
         CSR_COUNT_DISPATCHED:  cfg_shadow.count_dispatched = value[0];
         CSR_OP_SAMPLING_ON:    cfg_shadow.op_sampling_on = value[0];
         CSR_FETCH_SAMPLING_ON: cfg_shadow.fetch_sampling_on = value[0];
      endcase
   endtask

   // Period values weighted toward the clamp boundaries and the extremes.
   function automatic logic [PERIOD_W-1:0] pick_period();
      case ($urandom_range(4))
         0:       return '0;
         1:       return '1;
         2:       return PERIOD_W'($urandom_range(32'h900, 32'h700));
         3:       return PERIOD_W'($urandom_range(32'hFFFFF, 32'hFF700));
         default: return PERIOD_W'($urandom);
      endcase
   endfunction

   // A random single-bit register value, with the upper data bits as noise.
   function automatic logic [PERIOD_W-1:0] pick_flag(bit value);
      logic [PERIOD_W-1:0] d;
      d = PERIOD_W'($urandom);
      d[0] = value;
      return d;
   endfunction

   // Main stimulus sequence.
   initial begin
      stim_row_type row;
      req_type      item;
      rsp_type      typed;
      bit           cfg_open;
      bit           valid_bit;

      // Directed table: everything off after reset, then each command and corner.
      add_req_row(CMD_OP_START,    '0, 1, '0, 1'b0);
      add_req_row(CMD_OP_REARM,    '1, 1, '0, 1'b0);
      add_req_row(CMD_FETCH_START, '0, 1, '0, 1'b0);
      add_req_row(CMD_FETCH_REARM, '1, 1, '0, 1'b0);
      add_cfg_row(CSR_OP_SAMPLING_ON, 20'h1);
      add_cfg_row(CSR_FETCH_SAMPLING_ON, 20'h1);
      // Rearm before any start works from the cleared op word.
      add_req_row(CMD_OP_REARM, 64'h1 << OP_VAL_BIT, 0, '0, 1'b0);
      add_req_row(CMD_OP_REARM, ~(64'h1 << OP_VAL_BIT), 1, '0, 1'b0);
      add_req_row(CMD_OP_START, '0, 0, '0, 1'b0);
      add_cfg_row(CSR_OP_PERIOD, 20'hFFFFF);
      add_req_row(CMD_OP_START, '1, 0, '0, 1'b0);
      add_cfg_row(CSR_CUR_CNT_WRITABLE, 20'h1);
      add_req_row(CMD_OP_START, '0, 0, '0, 1'b0);
      add_cfg_row(CSR_OP_PERIOD, 20'h0);
      add_req_row(CMD_OP_START, '0, 0, '0, 1'b0);
      // The method changes between start and rearm.
      add_cfg_row(CSR_CUR_CNT_WRITABLE, 20'h0);
      add_req_row(CMD_OP_REARM, '1, 0, '0, 1'b0);
      add_cfg_row(CSR_DISPATCH_CAPABLE, 20'h1);
      add_cfg_row(CSR_COUNT_DISPATCHED, 20'h1);
      add_req_row(CMD_OP_START, '0, 0, '0, 1'b0);
      add_cfg_row(CSR_FETCH_PERIOD, 20'hFFFFF);
      add_cfg_row(CSR_FETCH_RANDOM_EN, 20'h1);
      add_req_row(CMD_FETCH_START, '0, 1, 64'h0201_0000_0000_FFFF, 1'b1);
      add_req_row(CMD_FETCH_REARM, '1, 1, 64'hFFFD_FFFF_0000_FFFF, 1'b1);
      add_req_row(CMD_FETCH_REARM, 64'h1 << FETCH_VAL_BIT, 1, 64'h1 << FETCH_ENABLE_BIT, 1'b1);
      add_req_row(CMD_FETCH_REARM, ~(64'h1 << FETCH_VAL_BIT), 1, '0, 1'b0);
      add_cfg_row(CSR_FETCH_PERIOD, 20'h0);
      add_cfg_row(CSR_FETCH_RANDOM_EN, 20'h0);
      add_req_row(CMD_FETCH_START, '1, 1, 64'h1 << FETCH_ENABLE_BIT, 1'b1);
      add_req_row(CMD_OP_REARM, 64'h1 << OP_VAL_BIT, 0, '0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with sender and receiver both idling.
      send_idle_pct = 22;
      recv_idle_pct = 71;
      cfg_open = 1'b0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_cfg) begin
            if (!cfg_open) wait_for_drain();
            write_reg(row.idx, row.wdata);
            cfg_open = 1'b1;
         end else begin
            if (cfg_open) csr_valid <= 1'b0;
            cfg_open = 1'b0;
            item.cmd = row.cmd;
            item.status_word = row.status;
            typed.control_word = row.exp_word;
            typed.write_word = row.exp_wr;
            send_request(item, row.has_exp, typed);
         end
      end

      // Random phases, each with fresh register settings; every three phases share an idle pattern.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_drain();
         case (p / 3)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_reg(CSR_OP_PERIOD, pick_period());
         write_reg(CSR_FETCH_PERIOD, pick_period());
         write_reg(CSR_FETCH_RANDOM_EN, pick_flag($urandom_range(1)));
         write_reg(CSR_CUR_CNT_WRITABLE, pick_flag($urandom_range(1)));
         write_reg(CSR_DISPATCH_CAPABLE, pick_flag($urandom_range(1)));
         write_reg(CSR_COUNT_DISPATCHED, pick_flag($urandom_range(1)));
         write_reg(CSR_OP_SAMPLING_ON, pick_flag($urandom_range(9) != 0));
         write_reg(CSR_FETCH_SAMPLING_ON, pick_flag($urandom_range(9) != 0));
         csr_valid <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            item.cmd = cmd_type'($urandom_range(3));
            item.status_word = {$urandom, $urandom};
            // Most rearms carry their valid bit so that they produce a word.
            valid_bit = ($urandom_range(3) != 0);
            item.status_word[OP_VAL_BIT] = valid_bit;
            item.status_word[FETCH_VAL_BIT] = valid_bit;
            send_request(item, 0, '0);
         end
      end

      // Let the last responses arrive, then report.
      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Checked %0d responses (%0d with a word to write) over %0d register writes,",
               words_checked, words_written, reg_writes);
      $display("a directed table and %0d random setting phases.", RANDOM_PHASES);
      if (mismatches == 0)
         $display("sampling_ctl_word_randomizer regression: pass");
      else
         $display("sampling_ctl_word_randomizer regression: fail");
      $finish;
   end

endmodule

/* sampling_ctl_word_randomizer.f */
sv/swr_pkg.sv
sv/swr_csr.sv
sv/swr_build.sv
sv/sampling_ctl_word_randomizer.sv
verif/tb_sampling_ctl_word_randomizer.sv
